>>> hdl/xbin_rle_cell_decoder_assert.svh
// ----------------------------------------------------------------------------
// XBIN RLE cell decoder assertion macros
// Concurrent assertion wrappers; they expand to nothing when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef XBIN_RLE_CELL_DECODER_ASSERT_SVH
`define XBIN_RLE_CELL_DECODER_ASSERT_SVH

`ifndef SYNTH

// Property must hold at every clock edge outside reset
`define XRLE_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("xrle assertion failed");

// Condition must never be true outside reset
`define XRLE_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("xrle forbidden condition seen");

`else

`define XRLE_ASSERT(lbl, clk, rst, prop)
`define XRLE_NEVER(lbl, clk, rst, cond)

`endif

`endif

>>> hdl/xrle_pkg.sv
// ----------------------------------------------------------------------------
// XBIN RLE cell decoder package
// Shared types, register indexes, parser phases and run types.
// ----------------------------------------------------------------------------
package xrle_pkg;

  // Default depth of the command queue between parser and expander
  localparam int unsigned CMD_DEPTH = 4;

  // Longest run a single header can describe
  localparam logic [6:0] MAX_RUN = 7'd64;

  // Configuration register indexes
  localparam logic [1:0] CFG_WIDTH      = 2'd0;
  localparam logic [1:0] CFG_HEIGHT     = 2'd1;
  localparam logic [1:0] CFG_COMPRESSED = 2'd2;
  localparam logic [1:0] CFG_NONBLINK   = 2'd3;

  // Register reset values
  localparam logic [15:0] WIDTH_RESET  = 16'd80;
  localparam logic [15:0] HEIGHT_RESET = 16'd25;

  // Run types from header bits 7..6
  localparam logic [1:0] RUN_LITERAL = 2'd0;
  localparam logic [1:0] RUN_CHAR    = 2'd1;
  localparam logic [1:0] RUN_ATTR    = 2'd2;
  localparam logic [1:0] RUN_PAIR    = 2'd3;

  // Parser phases
  typedef enum logic [2:0] {
    PH_HEADER    = 3'd0,
    PH_LIT_CHAR  = 3'd1,
    PH_LIT_ATTR  = 3'd2,
    PH_ONE_CHAR  = 3'd3,
    PH_EACH_ATTR = 3'd4,
    PH_ONE_ATTR  = 3'd5,
    PH_EACH_CHAR = 3'd6,
    PH_PAIR_ATTR = 3'd7
  } xrle_phase_t;

  // Configuration as seen by the parser
  typedef struct packed {
    logic [15:0] width_chars;
    logic [15:0] height_chars;
    logic        compressed;
    logic        nonblink;
  } xrle_cfg_t;

  // Input beat
  typedef struct packed {
    logic [7:0] in_byte;
    logic       start_of_image;
  } xrle_item_t;

  // Result beat
  typedef struct packed {
    logic [7:0] char_code;
    logic [3:0] fg_color;
    logic [3:0] bg_color;
    logic       blink;
    logic       last_of_run;
  } xrle_cell_t;

  // One queued command: a split cell repeated count times (1..64)
  typedef struct packed {
    logic [7:0] char_code;
    logic [3:0] fg_color;
    logic [3:0] bg_color;
    logic       blink;
    logic [6:0] count;
  } xrle_cmd_t;

endpackage

>>> hdl/xrle_front.sv
// ----------------------------------------------------------------------------
// XBIN RLE parser front end
// Takes one stream byte per beat, tracks run state and position, and
// issues a cell command for every byte that produces output.
// ----------------------------------------------------------------------------
module xrle_front
  import xrle_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  xrle_cfg_t  cfg,
  input  logic       accept,
  input  xrle_item_t item,
  output logic       cmd_wr,
  output xrle_cmd_t  cmd
);

  // Parser state
  xrle_phase_t phase, phase_next;
  logic [1:0]  run_type, run_type_next;
  logic [6:0]  run_left, run_left_next;
  logic [7:0]  held_char, held_char_next;
  logic [7:0]  held_attr, held_attr_next;
  logic [16:0] column, column_next;
  logic [15:0] row, row_next;
  logic        finished, finished_next;

  // State as seen after an optional start-of-image clear
  xrle_phase_t ph;
  logic [1:0]  rt;
  logic [6:0]  rl;
  logic [7:0]  hc, ha;
  logic [16:0] col;
  logic [15:0] rw;
  logic        fin;

  // Helpers
  logic [7:0]  b;
  logic [16:0] col_inc, col_h, width_ext;
  logic [15:0] row_inc, row_h;
  logic        col_wrap;
  logic [6:0]  rl_dec, pair_count, hdr_len;
  logic        emit;
  logic [7:0]  em_char, em_attr;
  logic [6:0]  em_count;
  logic        em_blink;

  assign b         = item.in_byte;
  assign width_ext = {1'b0, cfg.width_chars};

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HEADER;
      run_type  <= RUN_LITERAL;
      run_left  <= '0;
      held_char <= '0;
      held_attr <= '0;
      column    <= '0;
      row       <= '0;
      finished  <= 1'b0;
    end else if (accept) begin
      phase     <= phase_next;
      run_type  <= run_type_next;
      run_left  <= run_left_next;
      held_char <= held_char_next;
      held_attr <= held_attr_next;
      column    <= column_next;
      row       <= row_next;
      finished  <= finished_next;
    end
  end

  // Next state and command
  always_comb begin
    ph  = phase;
    rt  = run_type;
    rl  = run_left;
    hc  = held_char;
    ha  = held_attr;
    col = column;
    rw  = row;
    fin = finished;
    if (item.start_of_image) begin
      ph  = PH_HEADER;
      rt  = RUN_LITERAL;
      rl  = '0;
      hc  = '0;
      ha  = '0;
      col = '0;
      rw  = '0;
      fin = 1'b0;
    end

    col_inc    = col + 17'd1;
    row_inc    = rw + 16'd1;
    col_wrap   = col >= width_ext;
    row_h      = col_wrap ? row_inc : rw;
    col_h      = col_wrap ? '0 : col;
    rl_dec     = rl - 7'd1;
    pair_count = (rl > MAX_RUN) ? MAX_RUN : rl;
    hdr_len    = {1'b0, b[5:0]} + 7'd1;

    phase_next     = ph;
    run_type_next  = rt;
    run_left_next  = rl;
    held_char_next = hc;
    held_attr_next = ha;
    column_next    = col;
    row_next       = rw;
    finished_next  = fin;

    emit     = 1'b0;
    em_char  = hc;
    em_attr  = b;
    em_count = 7'd1;

    if (!fin) begin
      if (!cfg.compressed) begin
        // plain char/attribute pairs
        if (rw >= cfg.height_chars) begin
          finished_next = 1'b1;
        end else if (ph == PH_LIT_ATTR) begin
          emit       = 1'b1;
          phase_next = PH_HEADER;
          if (col_inc >= width_ext) begin
            column_next = '0;
            row_next    = row_inc;
            if (row_inc >= cfg.height_chars) begin
              finished_next = 1'b1;
            end
          end else begin
            column_next = col_inc;
          end
        end else begin
          held_char_next = b;
          phase_next     = PH_LIT_ATTR;
        end
      end else begin
        case (ph)
          PH_HEADER: begin
            row_next    = row_h;
            column_next = col_h;
            if (row_h >= cfg.height_chars) begin
              finished_next = 1'b1;
            end else begin
              run_type_next = b[7:6];
              run_left_next = hdr_len;
              column_next   = col_h + {10'd0, hdr_len};
              case (b[7:6])
                RUN_LITERAL: phase_next = PH_LIT_CHAR;
                RUN_ATTR:    phase_next = PH_ONE_ATTR;
                default:     phase_next = PH_ONE_CHAR;
              endcase
            end
          end
          PH_LIT_CHAR: begin
            held_char_next = b;
            phase_next     = PH_LIT_ATTR;
          end
          PH_LIT_ATTR: begin
            emit          = 1'b1;
            run_left_next = rl_dec;
            phase_next    = (rl_dec != '0) ? PH_LIT_CHAR : PH_HEADER;
          end
          PH_ONE_CHAR: begin
            held_char_next = b;
            phase_next     = (rt == RUN_PAIR) ? PH_PAIR_ATTR : PH_EACH_ATTR;
          end
          PH_EACH_ATTR: begin
            emit          = 1'b1;
            run_left_next = rl_dec;
            if (rl_dec == '0) phase_next = PH_HEADER;
          end
          PH_ONE_ATTR: begin
            held_attr_next = b;
            phase_next     = PH_EACH_CHAR;
          end
          PH_EACH_CHAR: begin
            emit          = 1'b1;
            em_char       = b;
            em_attr       = ha;
            run_left_next = rl_dec;
            if (rl_dec == '0) phase_next = PH_HEADER;
          end
          PH_PAIR_ATTR: begin
            // whole repeated pair goes out as one command
            held_attr_next = b;
            emit           = pair_count != '0;
            em_count       = pair_count;
            run_left_next  = '0;
            phase_next     = PH_HEADER;
          end
          default: begin
            phase_next = PH_HEADER;
          end
        endcase
      end
    end

    // attribute split: bit 7 is blink unless nonblink is set
    em_blink      = em_attr[7] & ~cfg.nonblink;
    cmd.char_code = em_char;
    cmd.fg_color  = em_attr[3:0];
    cmd.bg_color  = {em_attr[7] & ~em_blink, em_attr[6:4]};
    cmd.blink     = em_blink;
    cmd.count     = em_count;
    cmd_wr        = accept & emit;
  end

endmodule

>>> hdl/xrle_cmd_fifo.sv
// ----------------------------------------------------------------------------
// XBIN RLE command queue
// Short register queue that decouples the parser from the cell expander.
// ----------------------------------------------------------------------------
module xrle_cmd_fifo
  import xrle_pkg::*;
#(
  parameter int unsigned Depth = CMD_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      wr_en,
  input  xrle_cmd_t wr_data,
  output logic      full,
  input  logic      rd_en,
  output xrle_cmd_t rd_data,
  output logic      valid
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  xrle_cmd_t       slots [Depth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;
  logic            do_wr, do_rd;

  assign full    = count == FullCnt;
  assign valid   = count != '0;
  assign do_wr   = wr_en & ~full;
  assign do_rd   = rd_en & valid;
  assign rd_data = slots[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> hdl/xrle_back.sv
// ----------------------------------------------------------------------------
// XBIN RLE cell expander
// Turns queued commands into cells, one per cycle while the output register
// is free or popped; that register is read as the head of the result queue.
// ----------------------------------------------------------------------------
module xrle_back
  import xrle_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  input  xrle_cmd_t  cmd,
  output logic       cmd_take,
  output xrle_cell_t cell_data,
  output logic       empty,
  input  logic       pop,
  output logic       run_active
);

  xrle_cmd_t  run;
  logic [6:0] run_left;
  logic       out_valid;
  logic       advance;
  logic       run_last;

  assign empty    = ~out_valid;
  assign run_last = run_left == 7'd1;
  assign advance  = run_active & (~out_valid | pop);
  assign cmd_take = cmd_valid & (~run_active | (advance & run_last));

  // Run register
  always_ff @(posedge clk) begin
    if (rst) begin
      run_active <= 1'b0;
    end else if (cmd_take) begin
      run_active <= 1'b1;
    end else if (advance && run_last) begin
      run_active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      run      <= cmd;
      run_left <= cmd.count;
    end else if (advance) begin
      run_left <= run_left - 7'd1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      cell_data.char_code   <= run.char_code;
      cell_data.fg_color    <= run.fg_color;
      cell_data.bg_color    <= run.bg_color;
      cell_data.blink       <= run.blink;
      cell_data.last_of_run <= run_last;
    end
  end

endmodule

>>> hdl/xbin_rle_cell_decoder.sv
// ----------------------------------------------------------------------------
// XBIN RLE cell decoder
// Decodes a run-length compressed XBIN byte stream into text-mode cells.
//
//   channel  handshake             payload
//   -------  --------------------  ------------------------------------------
//   item     push / full           in_byte, start_of_image
//   cell     empty / pop           char_code, fg_color, bg_color, blink, last
//   cfg      cfg_valid / cfg_ready cfg_index, cfg_data (ready always high)
//
// One byte is accepted per cycle while the command queue has room.
// Cells leave at one per cycle while pop is high; one repeated pair gives
// up to 64 cells from the expander, which sets the rate on pair streams.
// A byte's first cell goes through the queue, run and output registers.
// Reset clears registers to defaults, the parser, queue and output register.
// pop low holds the output; the expander then stops and full rises once the
// queue is filled.
// ----------------------------------------------------------------------------
`include "xbin_rle_cell_decoder_assert.svh"

module xbin_rle_cell_decoder
  import xrle_pkg::*;
#(
  parameter int unsigned CmdDepth = CMD_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  xrle_item_t  item,
  output logic        empty,
  input  logic        pop,
  output xrle_cell_t  cell_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  xrle_cfg_t cfg;
  logic      accept;
  logic      cmd_wr, cmd_full, cmd_valid, cmd_take;
  xrle_cmd_t cmd_in, cmd_out;
  logic      run_active;

  assign cfg_ready = 1'b1;
  assign full      = cmd_full;
  assign accept    = push & ~cmd_full;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width_chars  <= WIDTH_RESET;
      cfg.height_chars <= HEIGHT_RESET;
      cfg.compressed   <= 1'b1;
      cfg.nonblink     <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_WIDTH:      cfg.width_chars  <= cfg_data;
        CFG_HEIGHT:     cfg.height_chars <= cfg_data;
        CFG_COMPRESSED: cfg.compressed   <= cfg_data[0];
        CFG_NONBLINK:   cfg.nonblink     <= cfg_data[0];
        default:        cfg.nonblink     <= cfg.nonblink;
      endcase
    end
  end

  // Parser
  xrle_front u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .accept (accept),
    .item   (item),
    .cmd_wr (cmd_wr),
    .cmd    (cmd_in)
  );

  // Command queue
  xrle_cmd_fifo #(
    .Depth (CmdDepth)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmd_wr),
    .wr_data (cmd_in),
    .full    (cmd_full),
    .rd_en   (cmd_take),
    .rd_data (cmd_out),
    .valid   (cmd_valid)
  );

  // Cell expander
  xrle_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd_out),
    .cmd_take   (cmd_take),
    .cell_data  (cell_data),
    .empty      (empty),
    .pop        (pop),
    .run_active (run_active)
  );

  // Checks
  `XRLE_NEVER(a_no_write_when_full, clk, rst, cmd_wr && cmd_full)
  `XRLE_ASSERT(a_non_last_has_run, clk, rst, (!empty && !cell_data.last_of_run) |-> run_active)
  `XRLE_ASSERT(a_no_cell_from_nothing, clk, rst, (empty && !run_active && !cmd_valid) |=> empty)

endmodule

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// XBIN RLE cell decoder testbench
// Drives compressed and plain XBIN byte streams into the decoder. A cell
// predictor follows every accepted beat and queues the cells it should cause.
// Each popped cell is checked field by field against the oldest queued one.
// Geometry, mode and blink handling change between phases while idle.
// ----------------------------------------------------------------------------
module tb_top;
  import xrle_pkg::*;

  // Cell predictor and store of cells still due from the decoder
  class cell_scoreboard;
    logic [15:0] width_chars;
    logic [15:0] height_chars;
    logic        compressed;
    logic        nonblink;

    xrle_phase_t parse_phase;
    logic [1:0]  run_type;
    logic [6:0]  run_left;
    logic [6:0]  run_length;
    logic [7:0]  held_char;
    logic [7:0]  held_attr;
    logic [16:0] column;
    logic [15:0] row;
    logic        finished;

    xrle_cell_t  cells_due[$];
    int unsigned fail_count;

    function new();
      width_chars  = WIDTH_RESET;
      height_chars = HEIGHT_RESET;
      compressed   = 1'b1;
      nonblink     = 1'b0;
      fail_count   = 0;
      clear_stream();
    endfunction

    function void clear_stream();
      parse_phase = PH_HEADER;
      run_type    = RUN_LITERAL;
      run_left    = '0;
      run_length  = '0;
      held_char   = '0;
      held_attr   = '0;
      column      = '0;
      row         = '0;
      finished    = 1'b0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] data);
      case (idx)
        CFG_WIDTH:      width_chars  = data;
        CFG_HEIGHT:     height_chars = data;
        CFG_COMPRESSED: compressed   = data[0];
        CFG_NONBLINK:   nonblink     = data[0];
        default: ;
      endcase
    endfunction

    function int pending();
      return cells_due.size();
    endfunction

    // Split an attribute byte into colours and blink
    function xrle_cell_t split_cell(logic [7:0] ch, logic [7:0] attr);
      xrle_cell_t c;
      logic [7:0] a;
      a = attr;
      c.blink = a[7] & ~nonblink;
      if (c.blink) a[7] = 1'b0;
      c.char_code   = ch;
      c.fg_color    = a[3:0];
      c.bg_color    = a[7:4];
      c.last_of_run = 1'b0;
      return c;
    endfunction

    // Advance the parser by one accepted byte; 0 when the byte is dropped
    function bit note_byte(xrle_item_t it);
      logic [7:0] b;
      xrle_cell_t due[$];
      b = it.in_byte;
      if (it.start_of_image) clear_stream();
      if (finished) return 1'b0;

      if (!compressed) begin
        // plain pairs; a pending attribute phase takes the byte as attribute
        if (row >= height_chars) begin
          finished = 1'b1;
          return 1'b0;
        end
        if (parse_phase == PH_LIT_ATTR) begin
          due.push_back(split_cell(held_char, b));
          parse_phase = PH_HEADER;
          column = column + 17'd1;
          if (column >= {1'b0, width_chars}) begin
            column = '0;
            row = row + 16'd1;
            if (row >= height_chars) finished = 1'b1;
          end
        end else begin
          held_char   = b;
          parse_phase = PH_LIT_ATTR;
        end
      end else begin
        case (parse_phase)
          PH_HEADER: begin
            // overflowing column moves to the next row, excess dropped
            if (column >= {1'b0, width_chars}) begin
              row = row + 16'd1;
              column = '0;
            end
            if (row >= height_chars) begin
              finished = 1'b1;
              return 1'b0;
            end
            run_type   = b[7:6];
            run_length = {1'b0, b[5:0]} + 7'd1;
            run_left   = run_length;
            column     = column + {10'd0, run_length};
            if (run_type == RUN_LITERAL) parse_phase = PH_LIT_CHAR;
            else if (run_type == RUN_ATTR) parse_phase = PH_ONE_ATTR;
            else parse_phase = PH_ONE_CHAR;
          end
          PH_LIT_CHAR: begin
            held_char   = b;
            parse_phase = PH_LIT_ATTR;
          end
          PH_LIT_ATTR: begin
            due.push_back(split_cell(held_char, b));
            run_left = run_left - 7'd1;
            parse_phase = (run_left != 0) ? PH_LIT_CHAR : PH_HEADER;
          end
          PH_ONE_CHAR: begin
            held_char   = b;
            parse_phase = (run_type == RUN_PAIR) ? PH_PAIR_ATTR : PH_EACH_ATTR;
          end
          PH_EACH_ATTR: begin
            due.push_back(split_cell(held_char, b));
            run_left = run_left - 7'd1;
            if (run_left == 0) parse_phase = PH_HEADER;
          end
          PH_ONE_ATTR: begin
            held_attr   = b;
            parse_phase = PH_EACH_CHAR;
          end
          PH_EACH_CHAR: begin
            due.push_back(split_cell(b, held_attr));
            run_left = run_left - 7'd1;
            if (run_left == 0) parse_phase = PH_HEADER;
          end
          PH_PAIR_ATTR: begin
            // whole repeated pair comes out of this one byte
            held_attr = b;
            for (int k = 0; k < run_left && k < 64; k++)
              due.push_back(split_cell(held_char, held_attr));
            run_left    = '0;
            parse_phase = PH_HEADER;
          end
          default: ;
        endcase
      end

      if (due.size() > 0) due[due.size() - 1].last_of_run = 1'b1;
      foreach (due[i]) cells_due.push_back(due[i]);
      return 1'b1;
    endfunction

    function void note_failure(string msg);
      fail_count++;
      if (fail_count <= 10) $display("%t: %s", $realtime, msg);
    endfunction

    // Compare one popped cell with the oldest one due
    function void check_cell(xrle_cell_t got);
      xrle_cell_t want;
      if (cells_due.size() == 0) begin
        note_failure($sformatf("cell with none due: char %02h fg %h bg %h blink %b last %b",
                               got.char_code, got.fg_color, got.bg_color, got.blink,
                               got.last_of_run));
        return;
      end
      want = cells_due.pop_front();
      if (got.char_code != want.char_code || got.fg_color != want.fg_color ||
          got.bg_color != want.bg_color || got.blink != want.blink ||
          got.last_of_run != want.last_of_run)
        note_failure($sformatf({"cell differs: want char %02h fg %h bg %h blink %b last %b,",
                                " got char %02h fg %h bg %h blink %b last %b"},
                               want.char_code, want.fg_color, want.bg_color, want.blink,
                               want.last_of_run, got.char_code, got.fg_color,
                               got.bg_color, got.blink, got.last_of_run));
    endfunction

    // Cells still due at the end count as failures
    function int unsigned close();
      if (cells_due.size() != 0) begin
        $display("%0d cells never arrived", cells_due.size());
        fail_count += cells_due.size();
      end
      return fail_count;
    endfunction
  endclass

  // Opening stream at reset settings: every run type and attribute extreme
  localparam int OPENING_LEN = 18;
  localparam logic [7:0] OPENING [OPENING_LEN] = '{
    8'h00, 8'h00, 8'hFF,                 // literal, one pair
    8'h41, 8'hFF, 8'h80, 8'h7F,          // repeated char, two attributes
    8'h82, 8'h8F, 8'h01, 8'hFE, 8'hAA,   // repeated attribute, three chars
    8'hFF, 8'h55, 8'hF0,                 // repeated pair, longest run
    8'hC0, 8'h20, 8'h07                  // repeated pair, single cell
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  xrle_item_t  item_in = '0;
  logic        empty;
  logic        pop = 1'b0;
  xrle_cell_t  cell_out;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_WIDTH;
  logic [15:0] cfg_data = '0;

  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  bit          byte_taken;

  cell_scoreboard sb = new();

  xbin_rle_cell_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item_in),
    .empty     (empty),
    .pop       (pop),
    .cell_data (cell_out),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Receiver: random stalls on the cell side
  always @(posedge clk) begin
    pop <= ($urandom_range(99) >= stall_pct);
  end

  // Check every cell beat
  always @(posedge clk) begin
    if (!rst && pop && !empty) sb.check_cell(cell_out);
  end

  // Offer one byte beat and hold it until the decoder takes it
  task automatic send_byte(input logic [7:0] b, input logic sop);
    xrle_item_t it;
    it.in_byte = b;
    it.start_of_image = sop;
    if ($urandom_range(99) < gap_pct) begin
      push <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    push <= 1'b1;
    item_in <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    byte_taken = sb.note_byte(it);
  endtask

  // Stop sending and wait for every due cell, then let the pipe settle
  task automatic drain(input int settle);
    push <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // Write all four registers back to back
  task automatic write_regs(input logic [15:0] w, input logic [15:0] h,
                            input logic comp, input logic nb);
    logic [1:0]  idx [4];
    logic [15:0] val [4];
    idx = '{CFG_WIDTH, CFG_HEIGHT, CFG_COMPRESSED, CFG_NONBLINK};
    val = '{w, h, {15'd0, comp}, {15'd0, nb}};
    cfg_valid <= 1'b1;
    for (int i = 0; i < 4; i++) begin
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      sb.write_reg(idx[i], val[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic void set_idling(input int mode);
    case (mode)
      0: begin gap_pct = 0;  stall_pct = 0;  end
      1: begin gap_pct = 79; stall_pct = 0;  end
      2: begin gap_pct = 0;  stall_pct = 79; end
      default: begin gap_pct = 26; stall_pct = 26; end
    endcase
  endfunction

  // Header byte: mostly short runs, now and then long or the longest
  function automatic logic [7:0] make_header();
    logic [1:0] kind;
    logic [5:0] len;
    kind = 2'($urandom_range(3));
    case ($urandom_range(19))
      0:       len = 6'd63;
      1, 2:    len = 6'($urandom_range(63));
      default: len = 6'($urandom_range(7));
    endcase
    return {kind, len};
  endfunction

  // Random stream following the parser: headers where one is due, random
  // content elsewhere, stray image starts and fresh images once finished
  task automatic run_phase(input int budget);
    int   used;
    int   tries;
    logic sop;
    logic [7:0] b;
    used  = 0;
    tries = 0;
    while (used < budget && tries < budget * 4) begin
      sop = ($urandom_range(99) < 2);
      if (sb.finished && $urandom_range(2) == 0) sop = 1'b1;
      if (sb.compressed && (sop || sb.parse_phase == PH_HEADER) &&
          $urandom_range(9) != 0)
        b = make_header();
      else
        b = 8'($urandom_range(255));
      send_byte(b, sop);
      tries++;
      if (byte_taken) used++;
      // occasional full pause until the decoder has caught up
      if ($urandom_range(99) < 2) drain(1);
    end
  endtask

  // Stimulus
  initial begin
    logic [15:0] w, h;
    logic        comp, nb;
    int          budget;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: every run type at reset settings
    for (int i = 0; i < OPENING_LEN; i++) send_byte(OPENING[i], i == 0);
    drain(10);

    // directed: one-cell image, run past the row end, then bytes ignored
    write_regs(16'd1, 16'd1, 1'b1, 1'b1);
    send_byte(8'hC1, 1'b1);
    send_byte(8'h41, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h12, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'h33, 1'b0);
    send_byte(8'h8F, 1'b0);
    drain(10);

    // random phases; stream state carries over unless an image starts
    for (int p = 0; p < 12; p++) begin
      budget = 44;
      case (p)
        0: begin w = 16'd1;     h = 16'd1;     comp = 1'b1; nb = 1'b0; end
        1: begin w = 16'hFFFF;  h = 16'hFFFF;  comp = 1'b1; nb = 1'b1; end
        2: begin w = 16'd0;     h = 16'd3;     comp = 1'b1; nb = 1'b0; end
        3: begin w = 16'd5;     h = 16'd0;     comp = 1'b0; nb = 1'b1; budget = 6; end
        4: begin
          w = 16'($urandom_range(1, 16)); h = 16'($urandom_range(1, 6));
          comp = 1'b0; nb = 1'($urandom_range(1));
        end
        5: begin w = 16'hFFFF;  h = 16'd2;     comp = 1'b0; nb = 1'b0; end
        default: begin
          w = 16'($urandom_range(1, 24)); h = 16'($urandom_range(1, 8));
          comp = ($urandom_range(3) != 0); nb = 1'($urandom_range(1));
        end
      endcase
      write_regs(w, h, comp, nb);
      set_idling(p % 4);
      run_phase(budget);
      drain(10);
    end

    set_idling(0);
    drain(20);
    if (sb.close() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  // Run limit
  initial begin
    #16_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

>>> files.f
+incdir+hdl
hdl/xrle_pkg.sv
hdl/xrle_front.sv
hdl/xrle_cmd_fifo.sv
hdl/xrle_back.sv
hdl/xbin_rle_cell_decoder.sv
dv/tb_top.sv
